// ===== hw/rtl/rpl_pkg.sv =====
// ============================================================================
// rpl_pkg
// Shared constants and the item type that travels along the position row.
// ============================================================================
package rpl_pkg;

    localparam int POSITIONS  = 1024;               // positions in the store
    localparam int POS_W      = 10;                 // width of a position index
    localparam int CNT_W      = 11;                 // width of position_count
    localparam int COLOR_W    = 32;                 // width of one color
    localparam int CELL_POS   = 32;                 // positions held by one cell
    localparam int CELL_OFF_W = $clog2(CELL_POS);   // index within a cell
    localparam int CELL_COUNT = POSITIONS / CELL_POS;
    localparam int CELL_IDX_W = POS_W - CELL_OFF_W; // index of a cell in the row

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(POSITIONS);
    localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(POSITIONS);

    // Opcodes carried on the input tuser
    localparam logic OP_PAINT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Register index 0 (position_count) sits at byte address 0
    localparam int                 PADDR_W             = 3;
    localparam logic               REG_POSITION_COUNT  = 1'b0; // paddr[2]

    typedef struct packed {
        logic               valid;
        logic               is_read;
        logic               empty;    // paint that changes nothing
        logic               oor;      // read index at or beyond the count
        logic [POS_W-1:0]   lo;
        logic [POS_W-1:0]   hi;       // already clipped to count - 1
        logic [COLOR_W-1:0] color;    // paint color, or gathered read color
    } rpl_item_t;

endpackage

// ===== hw/rtl/rpl_intake.sv =====
// ============================================================================
// rpl_intake
// Decodes an accepted transaction against the position count and registers it.
// ============================================================================
module rpl_intake
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      in_valid,
    input  logic                      opcode,
    input  logic [rpl_pkg::POS_W-1:0] first,
    input  logic [rpl_pkg::POS_W-1:0] last_pos,
    input  logic [rpl_pkg::COLOR_W-1:0] color,
    input  logic [rpl_pkg::CNT_W-1:0] position_count,
    output rpl_pkg::rpl_item_t        item
);
    import rpl_pkg::*;

    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] lo_ext;
    logic [CNT_W-1:0] hi_ext;
    rpl_item_t        item_reg;
    rpl_item_t        item_next;

    always_comb
    begin
        cnt_eff = (position_count > COUNT_MAX) ? COUNT_MAX : position_count;
        cnt_m1  = cnt_eff - CNT_W'(1);
        lo_ext  = {1'b0, first};
        hi_ext  = {1'b0, last_pos};

        item_next.valid   = in_valid;
        item_next.is_read = (opcode == OP_READ);
        item_next.oor     = (lo_ext >= cnt_eff);
        // drop a paint over an empty or fully clipped range
        item_next.empty   = (cnt_eff == '0) || (first > last_pos) || (lo_ext >= cnt_eff);
        item_next.lo      = first;
        item_next.hi      = (hi_ext > cnt_m1) ? cnt_m1[POS_W-1:0] : last_pos;
        // a read starts with color 0 and gathers its color in the owning cell
        item_next.color   = (opcode == OP_READ) ? '0 : color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign item = item_reg;

endmodule

// ===== hw/rtl/rpl_cell.sv =====
// ============================================================================
// rpl_cell
// One cell of the position row: holds a block of colors, paints the part of a
// passing range that falls in its block and serves reads of its positions.
// ============================================================================
module rpl_cell
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic [rpl_pkg::CELL_IDX_W-1:0] cell_idx,
    input  rpl_pkg::rpl_item_t             item_in,
    output rpl_pkg::rpl_item_t             item_out
);
    import rpl_pkg::*;

    logic [COLOR_W-1:0]  store_reg [CELL_POS];
    logic [CELL_POS-1:0] hit;
    logic [POS_W-1:0]    pos      [CELL_POS];
    logic                owns_read;
    rpl_item_t           item_reg;
    rpl_item_t           item_next;

    always_comb
    begin
        for (int j = 0; j < CELL_POS; j++)
        begin
            pos[j] = {cell_idx, CELL_OFF_W'(j)};
            hit[j] = item_in.valid && !item_in.is_read && !item_in.empty &&
                     (pos[j] >= item_in.lo) && (pos[j] <= item_in.hi);
        end
    end

    always_comb
    begin
        owns_read = item_in.valid && item_in.is_read && !item_in.oor &&
                    (item_in.lo[POS_W-1:CELL_OFF_W] == cell_idx);
        item_next = item_in;
        if (owns_read)
        begin
            item_next.color = store_reg[item_in.lo[CELL_OFF_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < CELL_POS; j++)
            begin
                store_reg[j] <= '0;
            end
            item_reg <= '0;
        end
        else if (advance)
        begin
            for (int j = 0; j < CELL_POS; j++)
            begin
                if (hit[j])
                begin
                    store_reg[j] <= item_in.color;
                end
            end
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

// ===== hw/rtl/range_paint_last_writer_core.sv =====
// ============================================================================
// range_paint_last_writer_core
// Color store with range paint and point read, built as a row of cells.
//
//  channel   direction  handshake               payload
//  --------  ---------  ----------------------  --------------------------------
//  s_axis    in         s_axis_tvalid/tready    tuser: opcode
//                                               tdata: first, last_pos, color
//  m_axis    out        m_axis_tvalid/tready    tuser: out_of_range
//                                               tdata: read_color
//  apb       in/out     psel/penable/pready     position_count at address 0
//
// One transaction enters per cycle while the row is not held. A read result
// passes through the intake register, the register of each cell and the
// output register; a paint produces no result. Reset clears every color to
// 0 in all cells at once and sets position_count to 1024. A stalled result
// holds the whole row still.
// ============================================================================
module range_paint_last_writer_core
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [55:0]                  s_axis_tdata,  // first[9:0], last_pos[19:10],
                                                        // color[51:20], zero[55:52]
    input  logic [0:0]                   s_axis_tuser,  // opcode[0]

    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [31:0]                  m_axis_tdata,  // read_color[31:0]
    output logic [0:0]                   m_axis_tuser,  // out_of_range[0]

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rpl_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import rpl_pkg::*;

    logic               advance;
    logic [CNT_W-1:0]   count_reg;
    logic               out_valid_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_oor_reg;
    rpl_item_t          link [CELL_COUNT+1];

    // The whole row moves together; hold it while a result waits untaken.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    // ------------------------------------------------------------------
    // Configuration port: one register, writes decoded on the word index
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = {{(32-CNT_W){1'b0}}, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_POSITION_COUNT))
        begin
            count_reg <= pwdata[CNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Intake: clip the range against the count, flag empty paints and
    // out-of-range reads
    // ------------------------------------------------------------------
    rpl_intake u_intake
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .in_valid       (s_axis_tvalid),
        .opcode         (s_axis_tuser[0]),
        .first          (s_axis_tdata[9:0]),
        .last_pos       (s_axis_tdata[19:10]),
        .color          (s_axis_tdata[51:20]),
        .position_count (count_reg),
        .item           (link[0])
    );

    // ------------------------------------------------------------------
    // Cell row: each cell owns CELL_POS positions. Items pass in order, so a
    // read sees every earlier paint by the time it reaches the owning cell.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < CELL_COUNT; k++)
    begin : g_cell
        rpl_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .cell_idx (CELL_IDX_W'(k)),
            .item_in  (link[k]),
            .item_out (link[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register: keep reads, drop paints
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= link[CELL_COUNT].valid && link[CELL_COUNT].is_read;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_color_reg <= link[CELL_COUNT].color;
            out_oor_reg   <= link[CELL_COUNT].oor;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_color_reg;
    assign m_axis_tuser[0] = out_oor_reg;

endmodule
